FILE: sv/hilp_pkg.sv
// hilp_pkg: types, codes and constants shared by the hex image line parser.
// No dependencies; every other file of the parser refers to it by scoped names.
`default_nettype none

package hilp_pkg;

    localparam int ADDR_W      = 17;
    localparam int BYTE_W      = 8;
    localparam int CHAR_W      = 8;
    localparam int OFFSET_W    = 16;
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 17;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [ADDR_W-1:0]   RAM_TOP_RESET  = 17'h0E000;
    localparam logic [OFFSET_W-1:0] ROM_BASE_RESET = 16'hF000;

    localparam logic [CFG_INDEX_W-1:0] CFG_RAM_TOP  = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_ROM_BASE = 1'b1;

    localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_COLON = 8'h3A;
    localparam logic [CHAR_W-1:0] CH_COMMA = 8'h2C;

    typedef enum logic [1:0] {
        KIND_RAM = 2'd0,
        KIND_ROM = 2'd1,
        KIND_ERR = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        PH_ADDR0   = 3'd0,
        PH_ADDR1   = 3'd1,
        PH_ADDR2   = 3'd2,
        PH_ADDR3   = 3'd3,
        PH_COLON   = 3'd4,
        PH_DATA_HI = 3'd5,
        PH_DATA_LO = 3'd6,
        PH_SEP     = 3'd7
    } phase_t;

    // one queued action: a data byte at a load address, or a missing-colon error
    typedef struct packed {
        logic              is_err;
        logic [ADDR_W-1:0] addr;
        logic [BYTE_W-1:0] data;
    } entry_t;

    typedef struct packed {
        logic [ADDR_W-1:0]   ram_top;
        logic [OFFSET_W-1:0] rom_base;
    } cfg_t;

    function automatic logic [3:0] hex_digit(input logic [CHAR_W-1:0] ch);
        logic [3:0] d;
        d = 4'd0;
        if (ch inside {[8'h30:8'h39]})
        begin
            d = ch[3:0];
        end
        else if (ch inside {[8'h41:8'h46], [8'h61:8'h66]})
        begin
            d = ch[3:0] + 4'd9;
        end
        return d;
    endfunction

endpackage

`default_nettype wire

FILE: sv/hilp_front.sv
// hilp_front: character parser; tracks line phase and load address and
// pushes data bytes and errors into the queue. Depends on hilp_pkg.
`default_nettype none

module hilp_front (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            accept,
    input  wire logic [hilp_pkg::CHAR_W-1:0]     char_code,
    output logic                                 push,
    output hilp_pkg::entry_t                     push_entry
);

    hilp_pkg::phase_t                   phase_reg, phase_next;
    logic [hilp_pkg::ADDR_W-1:0]        addr_reg, addr_next;
    logic [hilp_pkg::BYTE_W-1:0]        accum_reg, accum_next;
    logic                               aborted_reg, aborted_next;
    logic [3:0]                         digit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= hilp_pkg::PH_ADDR0;
            addr_reg    <= '0;
            accum_reg   <= '0;
            aborted_reg <= 1'b0;
        end
        else
        begin
            phase_reg   <= phase_next;
            addr_reg    <= addr_next;
            accum_reg   <= accum_next;
            aborted_reg <= aborted_next;
        end
    end

    always_comb
    begin
        digit        = hilp_pkg::hex_digit(char_code);
        phase_next   = phase_reg;
        addr_next    = addr_reg;
        accum_next   = accum_reg;
        aborted_next = aborted_reg;
        push         = 1'b0;
        push_entry   = '{is_err: 1'b0, addr: addr_reg, data: accum_reg};

        if (accept && !aborted_reg)
        begin
            if (char_code == hilp_pkg::CH_TAB || char_code == hilp_pkg::CH_CR ||
                char_code == hilp_pkg::CH_SPACE)
            begin
                phase_next = phase_reg;
            end
            else if (char_code == hilp_pkg::CH_LF)
            begin
                phase_next = hilp_pkg::PH_ADDR0;
            end
            else
            begin
                case (phase_reg)
                    hilp_pkg::PH_ADDR0:
                    begin
                        addr_next  = {13'd0, digit};
                        phase_next = hilp_pkg::PH_ADDR1;
                    end
                    hilp_pkg::PH_ADDR1, hilp_pkg::PH_ADDR2, hilp_pkg::PH_ADDR3:
                    begin
                        addr_next  = {1'b0, addr_reg[11:0], digit};
                        phase_next = hilp_pkg::phase_t'(phase_reg + 3'd1);
                    end
                    hilp_pkg::PH_COLON:
                    begin
                        if (char_code != hilp_pkg::CH_COLON)
                        begin
                            aborted_next = 1'b1;
                            push         = 1'b1;
                            push_entry   = '{is_err: 1'b1, addr: '0, data: char_code};
                        end
                        else
                        begin
                            phase_next = hilp_pkg::PH_DATA_HI;
                        end
                    end
                    hilp_pkg::PH_DATA_HI:
                    begin
                        accum_next = {4'd0, digit};
                        phase_next = hilp_pkg::PH_DATA_LO;
                    end
                    hilp_pkg::PH_DATA_LO:
                    begin
                        accum_next = {accum_reg[3:0], digit};
                        phase_next = hilp_pkg::PH_SEP;
                        // address saturates at 0x10000
                        if (!addr_reg[hilp_pkg::ADDR_W-1])
                        begin
                            push       = 1'b1;
                            push_entry = '{is_err: 1'b0, addr: addr_reg,
                                           data: {accum_reg[3:0], digit}};
                            addr_next  = addr_reg + 17'd1;
                        end
                    end
                    default:
                    begin
                        phase_next = (char_code == hilp_pkg::CH_COMMA) ?
                                     hilp_pkg::PH_DATA_HI : hilp_pkg::PH_ADDR0;
                    end
                endcase
            end
        end
    end

endmodule

`default_nettype wire

FILE: sv/hilp_queue.sv
// hilp_queue: short register FIFO between parser front and write back end.
// Depends on hilp_pkg for the entry type.
`default_nettype none

module hilp_queue #(
    parameter int DEPTH = hilp_pkg::QUEUE_DEPTH
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire hilp_pkg::entry_t  push_entry,
    input  wire logic              pop,
    output logic                   full,
    output logic                   not_empty,
    output hilp_pkg::entry_t       head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    hilp_pkg::entry_t   mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               do_push, do_pop;

    always_comb
    begin
        full      = (count_reg == FULL_CNT);
        not_empty = (count_reg != '0);
        head      = mem_reg[rd_ptr_reg];
        do_push   = push && !full;
        do_pop    = pop && not_empty;

        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (!do_push && do_pop)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

`default_nettype wire

FILE: sv/hilp_back.sv
// hilp_back: maps queued bytes onto RAM or ROM regions, drops gap bytes, passes
// errors on and holds the result in the output register. Depends on hilp_pkg.
`default_nettype none

module hilp_back (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire hilp_pkg::cfg_t                     cfg,
    input  wire logic                               q_not_empty,
    input  wire hilp_pkg::entry_t                   q_head,
    output logic                                    q_pop,
    input  wire logic                               out_stall,
    output logic                                    out_valid,
    output logic [1:0]                              kind,
    output logic [hilp_pkg::OFFSET_W-1:0]           target_address,
    output logic [hilp_pkg::BYTE_W-1:0]             byte_value
);

    logic                               valid_reg, valid_next;
    hilp_pkg::kind_t                    kind_reg, kind_next;
    logic [hilp_pkg::OFFSET_W-1:0]      target_reg, target_next;
    logic [hilp_pkg::BYTE_W-1:0]        byte_reg, byte_next;
    logic                               load_ok;
    logic                               emit;
    logic [hilp_pkg::OFFSET_W-1:0]      addr16;

    always_comb
    begin
        addr16      = q_head.addr[hilp_pkg::OFFSET_W-1:0];
        load_ok     = !valid_reg || !out_stall;
        q_pop       = q_not_empty && load_ok;
        emit        = 1'b0;
        kind_next   = kind_reg;
        target_next = target_reg;
        byte_next   = byte_reg;

        if (q_head.is_err)
        begin
            emit        = 1'b1;
            kind_next   = hilp_pkg::KIND_ERR;
            target_next = '0;
            byte_next   = q_head.data;
        end
        else if (!q_head.addr[hilp_pkg::ADDR_W-1])
        begin
            if (q_head.addr < cfg.ram_top)
            begin
                emit        = 1'b1;
                kind_next   = hilp_pkg::KIND_RAM;
                target_next = addr16;
                byte_next   = q_head.data;
            end
            else if (addr16 >= cfg.rom_base)
            begin
                emit        = 1'b1;
                kind_next   = hilp_pkg::KIND_ROM;
                target_next = addr16 - cfg.rom_base;
                byte_next   = q_head.data;
            end
        end

        valid_next = load_ok ? (q_pop && emit) : valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop && emit)
        begin
            kind_reg   <= kind_next;
            target_reg <= target_next;
            byte_reg   <= byte_next;
        end
    end

    assign out_valid      = valid_reg;
    assign kind           = kind_reg;
    assign target_address = target_reg;
    assign byte_value     = byte_reg;

endmodule

`default_nettype wire

FILE: sv/hex_image_line_parser.sv
// hex_image_line_parser: top level; configuration registers, parser front,
// queue and write back end. Depends on hilp_pkg, hilp_front, hilp_queue, hilp_back.
//
//  channel  | direction | handshake             | payload
//  ---------+-----------+-----------------------+-------------------------------------
//  input    | in        | in_valid / in_stall   | char_code
//  output   | out       | out_valid / out_stall | kind, target_address, byte_value
//  config   | in        | cfg_we                | cfg_index, cfg_data
//
// One character per cycle while in_stall is low; the parser front updates its phase
// in the cycle of the transfer. Results go through the queue and the output register.
// in_stall rises only while the QUEUE_DEPTH-entry queue is full.
// Reset clears phase, load address, abort flag, queue and output valid; config to defaults.
// Output stalls fill the queue and then stall the input.
`default_nettype none

module hex_image_line_parser #(
    parameter int QUEUE_DEPTH = hilp_pkg::QUEUE_DEPTH
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire logic [hilp_pkg::CHAR_W-1:0]       char_code,
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output logic [1:0]                             kind,
    output logic [hilp_pkg::OFFSET_W-1:0]          target_address,
    output logic [hilp_pkg::BYTE_W-1:0]            byte_value,
    input  wire logic                              cfg_we,
    input  wire logic [hilp_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [hilp_pkg::CFG_DATA_W-1:0]   cfg_data
);

    hilp_pkg::cfg_t     cfg_reg, cfg_next;
    logic               q_full;
    logic               q_not_empty;
    logic               q_pop;
    logic               push;
    hilp_pkg::entry_t   push_entry;
    hilp_pkg::entry_t   q_head;
    logic               accept;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                hilp_pkg::CFG_RAM_TOP:  cfg_next.ram_top  = cfg_data;
                hilp_pkg::CFG_ROM_BASE: cfg_next.rom_base = cfg_data[hilp_pkg::OFFSET_W-1:0];
                default:                cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.ram_top  <= hilp_pkg::RAM_TOP_RESET;
            cfg_reg.rom_base <= hilp_pkg::ROM_BASE_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign in_stall = q_full;
    assign accept   = in_valid && !q_full;

    hilp_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .char_code  (char_code),
        .push       (push),
        .push_entry (push_entry)
    );

    hilp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (q_pop),
        .full       (q_full),
        .not_empty  (q_not_empty),
        .head       (q_head)
    );

    hilp_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg_reg),
        .q_not_empty    (q_not_empty),
        .q_head         (q_head),
        .q_pop          (q_pop),
        .out_stall      (out_stall),
        .out_valid      (out_valid),
        .kind           (kind),
        .target_address (target_address),
        .byte_value     (byte_value)
    );

endmodule

`default_nettype wire

FILE: sv/hilp_checker.sv
// hilp_checker: port-level assertions for hex_image_line_parser, bound to the top.
// Depends on hilp_pkg for result kind codes.
`default_nettype none

module hilp_checker (
    input wire logic                              clk,
    input wire logic                              rst_n,
    input wire logic                              out_valid,
    input wire logic                              out_stall,
    input wire logic [1:0]                        kind,
    input wire logic [hilp_pkg::OFFSET_W-1:0]     target_address,
    input wire logic [hilp_pkg::BYTE_W-1:0]       byte_value
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("out_valid dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(kind) && $stable(target_address) &&
                                   $stable(byte_value))
        else $error("output payload changed while stalled");

    a_err_zero_addr: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == hilp_pkg::KIND_ERR |-> target_address == '0)
        else $error("error result with nonzero target address");

    // error aborts parsing, so it is the final transfer
    a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && kind == hilp_pkg::KIND_ERR |=> !out_valid)
        else $error("result after missing colon error");

endmodule

bind hex_image_line_parser hilp_checker u_hilp_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .kind           (kind),
    .target_address (target_address),
    .byte_value     (byte_value)
);

`default_nettype wire
